// File: design/cmva_pkg.sv
// ----------------------------------------------------------------------------
// cmva_pkg
// Shared types, widths and arithmetic helpers for the column-streaming
// matrix-vector accumulator.
// ----------------------------------------------------------------------------
package cmva_pkg;

    localparam int VALUE_W = 32;
    localparam int ROW_W   = 10;
    localparam int SUM_W   = 64;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [1:0] {
        KIND_INT8  = 2'd0,
        KIND_INT16 = 2'd1,
        KIND_INT32 = 2'd2,
        KIND_Q16   = 2'd3
    } elem_kind_t;

    function automatic logic signed [VALUE_W-1:0] element_value(
        input elem_kind_t          kind,
        input logic [VALUE_W-1:0]  raw
    );
        logic signed [VALUE_W-1:0] e;
        unique case (kind)
            KIND_INT8:  e = {{(VALUE_W-8){raw[7]}}, raw[7:0]};
            KIND_INT16: e = {{(VALUE_W-16){raw[15]}}, raw[15:0]};
            KIND_INT32: e = raw;
            KIND_Q16:   e = raw;
            default:    e = raw;
        endcase
        return e;
    endfunction

    // Integer kinds: move Q16.16 up to Q32.32, saturating outside 48 bits.
    function automatic logic signed [SUM_W-1:0] scale_product(
        input elem_kind_t              kind,
        input logic signed [SUM_W-1:0] p
    );
        logic                    fits;
        logic signed [SUM_W-1:0] r;
        fits = (p[SUM_W-1:47] == '0) || (p[SUM_W-1:47] == '1);
        if (kind == KIND_Q16)
            r = p;
        else if (fits)
            r = {p[SUM_W-17:0], 16'h0000};
        else if (p[SUM_W-1])
            r = SUM_MIN;
        else
            r = SUM_MAX;
        return r;
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] b
    );
        logic [SUM_W:0]          s;
        logic signed [SUM_W-1:0] r;
        s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (s[SUM_W] != s[SUM_W-1])
            r = s[SUM_W] ? SUM_MIN : SUM_MAX;
        else
            r = s[SUM_W-1:0];
        return r;
    endfunction

endpackage

// File: design/cmva_ifs.sv
// ----------------------------------------------------------------------------
// cmva channel interfaces
// Valid/ready channels for matrix items, finished row sums and the
// element format register.
// ----------------------------------------------------------------------------
interface cmva_in_if;
    logic                      valid;
    logic                      ready;
    logic signed [31:0]        matrix_value;
    logic signed [31:0]        weight;
    logic [9:0]                row_pos;
    logic                      first_col;
    logic                      last_col;

    modport source (output valid, matrix_value, weight, row_pos, first_col, last_col,
                    input ready);
    modport sink   (input valid, matrix_value, weight, row_pos, first_col, last_col,
                    output ready);
endinterface

interface cmva_out_if;
    logic                      valid;
    logic                      ready;
    logic [9:0]                out_row;
    logic signed [63:0]        row_sum;

    modport source (output valid, out_row, row_sum, input ready);
    modport sink   (input valid, out_row, row_sum, output ready);
endinterface

interface cmva_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                element_kind;

    modport source (output valid, element_kind, input ready);
    modport sink   (input valid, element_kind, output ready);
endinterface

// File: design/column_stream_matvec_accumulator_unit.sv
// ----------------------------------------------------------------------------
// column_stream_matvec_accumulator_unit
// Column-major matrix-vector multiply-accumulate with per-row Q32.32 sums.
// ----------------------------------------------------------------------------
// Takes one matrix element per cycle, multiplies it by its column weight and
// adds it into the accumulator of its row (entry row_pos modulo MAX_ROWS); a
// first-column element starts the row fresh and a last-column element emits
// the row's saturated sum. An accepted transaction moves through tag1_reg,
// tag2_reg and tag3_reg into the result register. The rate is one transaction
// per clock, set by the single read-modify-write of the accumulator memory
// per cycle, with the write in flight forwarded to the following read. The
// whole pipeline holds only while a finished result waits and the result
// sink is not ready. Accumulator contents are undefined until a row is
// started by a first-column element; no clearing pass is run.
module column_stream_matvec_accumulator_unit
    import cmva_pkg::*;
#(
    parameter int MAX_ROWS = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    cmva_in_if.sink    item,
    cmva_out_if.source result,
    cmva_cfg_if.sink   cfg
);

    localparam int IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [ROW_W-1:0] row;
    } stage_tag_t;

    elem_kind_t              kind_reg;
    logic                    adv;
    logic                    accept;
    stage_tag_t              tag1_reg;
    stage_tag_t              tag2_reg;
    stage_tag_t              tag3_reg;
    logic [IDX_W-1:0]        idx_s1;
    logic [IDX_W-1:0]        idx2_reg;
    logic [IDX_W-1:0]        idx3_reg;
    logic signed [SUM_W-1:0] prod;
    logic signed [SUM_W-1:0] rd_data;
    logic signed [SUM_W-1:0] acc;
    logic                    out_valid_reg;
    logic [ROW_W-1:0]        out_row_reg;
    logic signed [SUM_W-1:0] out_sum_reg;

    assign adv    = !out_valid_reg || result.ready;
    assign accept = item.valid && adv;

    assign item.ready = adv;
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kind_reg <= KIND_Q16;
        else if (cfg.valid)
            kind_reg <= elem_kind_t'(cfg.element_kind);
    end

    // advance the control pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg      <= '0;
            tag2_reg      <= '0;
            tag3_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            tag1_reg      <= '{valid: accept, first: item.first_col,
                               last: item.last_col, row: item.row_pos};
            tag2_reg      <= tag1_reg;
            tag3_reg      <= tag2_reg;
            out_valid_reg <= tag3_reg.valid && tag3_reg.last;
        end
    end

    generate
        if (MAX_ROWS >= (1 << ROW_W))
        begin : g_idx_direct
            assign idx_s1 = IDX_W'(tag1_reg.row);
        end
        else
        begin : g_idx_mod
            localparam int RECIP_SH = 2 * ROW_W;
            localparam int RECIP    = ((1 << RECIP_SH) + MAX_ROWS - 1) / MAX_ROWS;
            localparam int QP_W     = ROW_W + RECIP_SH + 1;

            logic [QP_W-1:0]       qprod;
            logic [ROW_W-1:0]      quot_reg;
            logic [RECIP_SH-1:0]   qm;
            logic [ROW_W-1:0]      rem;

            assign qprod = QP_W'(item.row_pos) * QP_W'(RECIP);

            always_ff @(posedge clk)
            begin
                if (adv)
                    quot_reg <= qprod[RECIP_SH +: ROW_W];
            end

            assign qm     = RECIP_SH'(quot_reg) * RECIP_SH'(MAX_ROWS);
            assign rem    = tag1_reg.row - qm[ROW_W-1:0];
            assign idx_s1 = IDX_W'(rem);
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            idx2_reg <= idx_s1;
            idx3_reg <= idx2_reg;
        end
    end

    cmva_product u_product (
        .clk          (clk),
        .adv          (adv),
        .kind         (kind_reg),
        .matrix_value (item.matrix_value),
        .weight       (item.weight),
        .prod         (prod)
    );

    cmva_acc_ram #(
        .DEPTH (MAX_ROWS),
        .IDX_W (IDX_W)
    ) u_acc_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (adv),
        .rd_idx  (idx2_reg),
        .wr_en   (tag3_reg.valid && adv),
        .wr_idx  (idx3_reg),
        .wr_data (acc),
        .rd_data (rd_data)
    );

    assign acc = tag3_reg.first ? prod : sat_add(rd_data, prod);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_row_reg <= tag3_reg.row;
            out_sum_reg <= acc;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.out_row = out_row_reg;
    assign result.row_sum = out_sum_reg;

endmodule

// File: design/cmva_product.sv
// ----------------------------------------------------------------------------
// cmva_product
// Three-stage product path: element decode, 32x32 multiply, Q32.32 scaling.
// ----------------------------------------------------------------------------
module cmva_product
    import cmva_pkg::*;
(
    input  logic                      clk,
    input  logic                      adv,
    input  elem_kind_t                kind,
    input  logic signed [VALUE_W-1:0] matrix_value,
    input  logic signed [VALUE_W-1:0] weight,
    output logic signed [SUM_W-1:0]   prod
);

    logic signed [VALUE_W-1:0] elem_reg;
    logic signed [VALUE_W-1:0] weight_reg;
    logic signed [SUM_W-1:0]   mul_reg;
    logic signed [SUM_W-1:0]   prod_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            elem_reg   <= element_value(kind, matrix_value);
            weight_reg <= weight;
            mul_reg    <= SUM_W'(elem_reg) * SUM_W'(weight_reg);
            prod_reg   <= scale_product(kind, mul_reg);
        end
    end

    assign prod = prod_reg;

endmodule

// File: design/cmva_acc_ram.sv
// ----------------------------------------------------------------------------
// cmva_acc_ram
// Row accumulator memory: one read and one write per cycle, registered read,
// with the same-cycle write forwarded to the read.
// ----------------------------------------------------------------------------
module cmva_acc_ram
    import cmva_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int IDX_W = 10
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    rd_en,
    input  logic [IDX_W-1:0]        rd_idx,
    input  logic                    wr_en,
    input  logic [IDX_W-1:0]        wr_idx,
    input  logic signed [SUM_W-1:0] wr_data,
    output logic signed [SUM_W-1:0] rd_data
);

    logic signed [SUM_W-1:0] mem [DEPTH];
    logic signed [SUM_W-1:0] mem_q_reg;
    logic signed [SUM_W-1:0] fwd_data_reg;
    logic                    fwd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx] <= wr_data;
        if (rd_en)
        begin
            mem_q_reg    <= mem[rd_idx];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_hit_reg <= 1'b0;
        else if (rd_en)
            fwd_hit_reg <= wr_en && (wr_idx == rd_idx);
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : mem_q_reg;

endmodule

// File: design/cmva_checker.sv
// ----------------------------------------------------------------------------
// cmva_checker
// Port-level checks for the matrix-vector accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module cmva_checker
    import cmva_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    item_valid,
    input logic                    item_ready,
    input logic                    item_last,
    input logic                    result_valid,
    input logic                    result_ready,
    input logic [ROW_W-1:0]        result_row,
    input logic signed [SUM_W-1:0] result_sum
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result transaction dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result_row) && $stable(result_sum))
        else $error("result payload changed while stalled");

    a_ready_follows_sink: assert property (@(posedge clk) disable iff (!rst_n)
        result_ready |-> item_ready)
        else $error("input stalled while result sink is ready");

    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        result_ready && $past(result_ready) && $past(result_ready, 2)
        && $past(result_ready, 3) && $past(rst_n) && $past(rst_n, 2)
        && $past(rst_n, 3)
        && $past(item_valid && item_ready && item_last, 3)
        |=> result_valid)
        else $error("last-column transaction produced no result");

endmodule

bind column_stream_matvec_accumulator_unit cmva_checker u_cmva_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_last    (item.last_col),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_row   (result.out_row),
    .result_sum   (result.row_sum)
);

// File: tb/row_sum_tracker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// row_sum_tracker
// Watches the item, result and format channels of the column-stream
// matrix-vector accumulator, keeps its own per-row Q32.32 sums and the
// element format, and compares every finished row sum, field by field,
// with the oldest expected one.
// ----------------------------------------------------------------------------
module row_sum_tracker
    import cmva_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    cmva_in_if   items,
    cmva_out_if  sums,
    cmva_cfg_if  kind_wr,
    output int   error_count,
    output int   pending_sums
);

    localparam logic signed [63:0] INT_PROD_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] INT_PROD_MIN = 64'shFFFF_8000_0000_0000;
    localparam int                 MAX_PRINTS   = 100;

    typedef struct {
        logic [9:0]         row;
        logic signed [63:0] total;
    } row_sum_t;

    row_sum_t           expected_sums[$];
    logic signed [63:0] row_acc [1024];
    elem_kind_t         kind;

    function automatic logic signed [63:0] scaled_product(
        input elem_kind_t  k,
        input logic [31:0] raw,
        input logic [31:0] wt
    );
        longint elem;
        longint prod;
        case (k)
            KIND_INT8:  elem = longint'($signed(raw[7:0]));
            KIND_INT16: elem = longint'($signed(raw[15:0]));
            default:    elem = longint'($signed(raw));
        endcase
        prod = elem * longint'($signed(wt));
        if (k == KIND_Q16)
            return prod;
        if (prod > INT_PROD_MAX)
            return SUM_MAX;
        if (prod < INT_PROD_MIN)
            return SUM_MIN;
        return prod <<< 16;
    endfunction

    function automatic logic signed [63:0] saturating_sum(
        input logic signed [63:0] a,
        input logic signed [63:0] b
    );
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            return a[63] ? SUM_MIN : SUM_MAX;
        return s;
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTS)
            $display("%0t row_sum_tracker: %s", $time, what);
        error_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        row_sum_t           oldest;
        logic signed [63:0] prod;
        logic signed [63:0] acc;
        if (!rst_n)
        begin
            kind = KIND_Q16;
            expected_sums.delete();
            error_count = 0;
            pending_sums <= 0;
        end
        else
        begin
            if (kind_wr.valid && kind_wr.ready)
                kind = elem_kind_t'(kind_wr.element_kind);

            if (sums.valid && sums.ready)
            begin
                if (expected_sums.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected sum row %0d value %h",
                                              sums.out_row, sums.row_sum));
                end
                else
                begin
                    oldest = expected_sums.pop_front();
                    if (sums.out_row !== oldest.row)
                        report_mismatch($sformatf("out_row %0d, want %0d",
                                                  sums.out_row, oldest.row));
                    if (sums.row_sum !== oldest.total)
                        report_mismatch($sformatf("row %0d row_sum %h, want %h",
                                                  oldest.row, sums.row_sum, oldest.total));
                end
            end

            if (items.valid && items.ready)
            begin
                prod = scaled_product(kind, items.matrix_value, items.weight);
                if (items.first_col)
                    acc = prod;
                else
                    acc = saturating_sum(row_acc[items.row_pos], prod);
                row_acc[items.row_pos] = acc;
                if (items.last_col)
                    expected_sums.push_back('{row: items.row_pos, total: acc});
            end

            pending_sums <= expected_sums.size();
        end
    end

endmodule

// File: tb/tb_column_stream_matvec_accumulator_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_column_stream_matvec_accumulator_unit
// Drives column-major matrix streams with random content, loose and broken
// sequences through every element format, with random source gaps, sink
// stalls and one long sink hold-off, and reports the tracker's verdict.
// ----------------------------------------------------------------------------
module tb_column_stream_matvec_accumulator_unit;
    import cmva_pkg::*;

    localparam int NUM_PHASES      = 9;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int PRESSURE_PHASE  = 5;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 12;

    logic clk;
    logic rst_n;

    cmva_in_if  item_ch ();
    cmva_out_if sum_ch ();
    cmva_cfg_if cfg_ch ();

    int   error_count;
    int   pending_sums;
    int   idle_pct;
    int   stall_pct;
    logic hold_request;
    int   items_sent;
    bit   row_started [1024];

    elem_kind_t phase_kind [NUM_PHASES] = '{KIND_Q16, KIND_INT8, KIND_INT16, KIND_INT32,
                                            KIND_Q16, KIND_INT32, KIND_INT8, KIND_INT16,
                                            KIND_Q16};
    int phase_idle  [NUM_PHASES] = '{0, 57, 0, 7, 57, 0, 57, 0, 7};
    int phase_stall [NUM_PHASES] = '{0, 0, 57, 7, 57, 0, 0, 57, 7};

    column_stream_matvec_accumulator_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (sum_ch),
        .cfg    (cfg_ch)
    );

    row_sum_tracker u_row_sum_tracker (
        .clk          (clk),
        .rst_n        (rst_n),
        .items        (item_ch),
        .sums         (sum_ch),
        .kind_wr      (cfg_ch),
        .error_count  (error_count),
        .pending_sums (pending_sums)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("tb_column_stream_matvec_accumulator_unit: errors");
        $finish;
    end

    initial
    begin : sink_side
        int hold_left;
        hold_left = 0;
        sum_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0)
            begin
                sum_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                sum_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        case ($urandom_range(0, 3))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       w = 32'h7FFF_FFFF;
                    1:       w = 32'h8000_0000;
                    2:       w = 32'h0000_0000;
                    3:       w = 32'hFFFF_FFFF;
                    default: w = 32'h0001_0000;
                endcase
            end
            1:       w = 32'($urandom_range(0, 511)) - 32'd256;
            default: w = $urandom;
        endcase
        return w;
    endfunction

    task automatic send_item(
        input logic [31:0] value,
        input logic [31:0] wt,
        input logic [9:0]  row,
        input bit          first,
        input bit          last
    );
        while ($urandom_range(0, 99) < idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.matrix_value <= value;
        item_ch.weight       <= wt;
        item_ch.row_pos      <= row;
        item_ch.first_col    <= first;
        item_ch.last_col     <= last;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        if (first)
            row_started[row] = 1'b1;
        items_sent++;
    endtask

    task automatic send_edge_cases();
        send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 10'd0,     1'b1, 1'b0);
        send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 10'd0,     1'b0, 1'b0);
        send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 10'd0,     1'b0, 1'b1);
        send_item(32'h8000_0000, 32'h7FFF_FFFF, 10'd1023,  1'b1, 1'b0);
        send_item(32'h8000_0000, 32'h7FFF_FFFF, 10'd1023,  1'b0, 1'b1);
        send_item(32'h1234_5680, 32'h8000_0000, 10'h155,   1'b1, 1'b1);
    endtask

    task automatic run_matrix();
        logic [9:0]  rows [6];
        logic [31:0] col_weight;
        int          n_rows;
        int          n_cols;
        int          left;
        n_rows = $urandom_range(1, 6);
        n_cols = $urandom_range(1, 5);
        left   = n_rows * n_cols;
        if ($urandom_range(0, 9) == 0)
            left = $urandom_range(1, n_rows * n_cols);
        for (int r = 0; r < n_rows; r++)
            rows[r] = 10'($urandom_range(0, 1023));
        for (int c = 0; c < n_cols; c++)
        begin
            col_weight = rand_word();
            for (int r = 0; r < n_rows; r++)
            begin
                if (left == 0)
                    return;
                send_item(rand_word(), col_weight, rows[r], c == 0, c == n_cols - 1);
                left--;
            end
        end
    endtask

    task automatic send_loose_item();
        logic [9:0] row;
        bit         first;
        row   = 10'($urandom_range(0, 1023));
        first = row_started[row] ? 1'($urandom_range(0, 1)) : 1'b1;
        send_item(rand_word(), rand_word(), row, first, 1'($urandom_range(0, 1)));
    endtask

    task automatic write_kind(input elem_kind_t k);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.element_kind <= k;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_sums != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin : source_side
        int target;
        rst_n                <= 1'b0;
        item_ch.valid        <= 1'b0;
        item_ch.matrix_value <= '0;
        item_ch.weight       <= '0;
        item_ch.row_pos      <= '0;
        item_ch.first_col    <= 1'b0;
        item_ch.last_col     <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.element_kind  <= KIND_Q16;
        hold_request         <= 1'b0;
        stall_pct            <= 0;
        idle_pct   = 0;
        items_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_drained();
            write_kind(phase_kind[ph]);
            idle_pct = phase_idle[ph];
            stall_pct <= phase_stall[ph];
            if (ph == PRESSURE_PHASE)
                hold_request <= 1'b1;
            @(posedge clk);
            hold_request <= 1'b0;
            if (ph < 4)
                send_edge_cases();
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target)
            begin
                if ($urandom_range(0, 99) < 80)
                    run_matrix();
                else
                    send_loose_item();
            end
            item_ch.valid <= 1'b0;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_column_stream_matvec_accumulator_unit: clean");
        else
            $display("tb_column_stream_matvec_accumulator_unit: errors");
        $finish;
    end

endmodule
